// ----- design/lirs_pkg.sv -----
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared constants, codes and types of the LIRS replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lirs_pkg;

  localparam int LINES     = 1024;
  localparam int IDX_W     = $clog2(LINES);
  localparam int ID_W      = 10;
  localparam int CNT_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_MAX       = '1;
  localparam logic [CNT_W-1:0] LIR_LIMIT_RST = CNT_W'(992);
  localparam logic [CNT_W-1:0] HIR_LIMIT_RST = CNT_W'(32);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIR_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIR_LIMIT = 1'd1;

  // per-line mark and list membership
  typedef struct packed {
    logic hir;
    logic ins;
    logic inq;
  } flags_t;

  localparam int FLAGS_W = $bits(flags_t);

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    flags_t           wdata;
  } flag_req_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
  } link_req_t;

endpackage

`default_nettype wire

// ----- design/lirs_if.sv -----
// ----------------------------------------------------------------------------
// lirs_if
// Channel interfaces: access input, result output, configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lirs_in_if import lirs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] line_id;
  modport source (output valid, output line_id, input ready);
  modport sink   (input valid, input line_id, output ready);
endinterface

interface lirs_out_if import lirs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            evicted;
  logic [ID_W-1:0] victim_id;
  logic            line_is_hir;
  modport source (output valid, output evicted, output victim_id, output line_is_hir,
                  input ready);
  modport sink   (input valid, input evicted, input victim_id, input line_is_hir,
                  output ready);
endinterface

interface lirs_cfg_if import lirs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/lirs_ram.sv -----
// ----------------------------------------------------------------------------
// lirs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]              rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/lirs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lirs_ctrl
// Sequencer: list updates over the flag and link memories, prune, eviction.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_ctrl import lirs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  lirs_in_if.sink               in_ch,
  lirs_out_if.source            out_ch,
  lirs_cfg_if.sink              cfg_ch,
  output flag_req_t             fl_req,
  input  wire logic [FLAGS_W-1:0] fl_rdata,
  output link_req_t             sp_req,
  output link_req_t             sn_req,
  output link_req_t             qp_req,
  output link_req_t             qn_req,
  input  wire logic [IDX_W-1:0] sp_rdata,
  input  wire logic [IDX_W-1:0] sn_rdata,
  input  wire logic [IDX_W-1:0] qp_rdata,
  input  wire logic [IDX_W-1:0] qn_rdata
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_FX, ST_XQPUSH, ST_HB, ST_HC, ST_HD, ST_HE, ST_HF,
    ST_LC, ST_PR, ST_PR2, ST_CHECK, ST_EV, ST_RM_A, ST_RM_B, ST_FIN
  } state_t;

  state_t           state_r, state_nxt, ret_r, ret_nxt;
  logic [IDX_W-1:0] x_r, x_nxt, b_r, b_nxt, ry_r, ry_nxt, vic_r, vic_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  flags_t           f;
  logic             rsel_r, rsel_nxt;
  logic             chk_r, chk_nxt, hx_r, hx_nxt, ev_r, ev_nxt;
  logic [IDX_W-1:0] s_bot_r, s_bot_nxt, s_top_r, s_top_nxt;
  logic [IDX_W-1:0] q_bot_r, q_bot_nxt, q_top_r, q_top_nxt;
  logic             s_ne_r, s_ne_nxt, q_ne_r, q_ne_nxt;
  logic [CNT_W-1:0] lir_cnt_r, lir_cnt_nxt, hir_cnt_r, hir_cnt_nxt;
  logic [CNT_W-1:0] lir_lim_r, lir_lim_nxt, hir_lim_r, hir_lim_nxt;
  logic             out_valid_r, out_valid_nxt, out_ev_r, out_ev_nxt;
  logic             out_hx_r, out_hx_nxt;
  logic [ID_W-1:0]  out_vic_r, out_vic_nxt;
  logic             push_s, push_q;
  logic [IDX_W-1:0] push_y, rm_p, rm_n, rm_bot, rm_top;
  logic             rm_ne;

  localparam logic SEL_S = 1'b0;
  localparam logic SEL_Q = 1'b1;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.evicted    = out_ev_r;
  assign out_ch.victim_id  = out_vic_r;
  assign out_ch.line_is_hir = out_hx_r;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    x_nxt       = x_r;
    b_nxt       = b_r;
    ry_nxt      = ry_r;
    vic_nxt     = vic_r;
    clr_nxt     = clr_r;
    rsel_nxt    = rsel_r;
    chk_nxt     = chk_r;
    hx_nxt      = hx_r;
    ev_nxt      = ev_r;
    s_bot_nxt   = s_bot_r;
    s_top_nxt   = s_top_r;
    s_ne_nxt    = s_ne_r;
    q_bot_nxt   = q_bot_r;
    q_top_nxt   = q_top_r;
    q_ne_nxt    = q_ne_r;
    lir_cnt_nxt = lir_cnt_r;
    hir_cnt_nxt = hir_cnt_r;
    lir_lim_nxt = lir_lim_r;
    hir_lim_nxt = hir_lim_r;
    out_valid_nxt = out_valid_r;
    out_ev_nxt  = out_ev_r;
    out_vic_nxt = out_vic_r;
    out_hx_nxt  = out_hx_r;
    fl_req      = '0;
    sp_req      = '0;
    sn_req      = '0;
    qp_req      = '0;
    qn_req      = '0;
    push_s      = 1'b0;
    push_q      = 1'b0;
    push_y      = x_r;
    f           = flags_t'(fl_rdata);
    rm_p        = rsel_r ? qp_rdata : sp_rdata;
    rm_n        = rsel_r ? qn_rdata : sn_rdata;
    rm_bot      = rsel_r ? q_bot_r : s_bot_r;
    rm_top      = rsel_r ? q_top_r : s_top_r;
    rm_ne       = rsel_r ? q_ne_r : s_ne_r;

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_LIR_LIMIT: lir_lim_nxt = cfg_ch.data;
        CFG_HIR_LIMIT: hir_lim_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        fl_req.we    = 1'b1;
        fl_req.waddr = clr_r;
        fl_req.wdata = '0;
        clr_nxt      = clr_r + 1'b1;
        if (clr_r == IDX_W'(LINES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          x_nxt   = IDX_W'(in_ch.line_id);
          chk_nxt = 1'b0;
          ev_nxt  = 1'b0;
          hx_nxt  = 1'b0;
          vic_nxt = '0;
          if (32'(in_ch.line_id) < LINES) begin
            fl_req.re    = 1'b1;
            fl_req.raddr = IDX_W'(in_ch.line_id);
            state_nxt    = ST_FX;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FX: begin
        fl_req.we    = 1'b1;
        fl_req.waddr = x_r;
        ry_nxt       = x_r;
        if (!f.ins) begin
          push_s = 1'b1;
          if (lir_cnt_r != lir_lim_r) begin
            // new line as LIR, dropped from the queue if still there
            lir_cnt_nxt  = (lir_cnt_r == CNT_MAX) ? lir_cnt_r : lir_cnt_r + 1'b1;
            fl_req.wdata = '{hir: 1'b0, ins: 1'b1, inq: 1'b0};
            if (f.inq) begin
              hir_cnt_nxt = (hir_cnt_r == '0) ? hir_cnt_r : hir_cnt_r - 1'b1;
              rsel_nxt    = SEL_Q;
              ret_nxt     = ST_FIN;
              state_nxt   = ST_RM_A;
            end else begin
              state_nxt = ST_FIN;
            end
          end else begin
            fl_req.wdata = '{hir: 1'b1, ins: 1'b1, inq: 1'b1};
            hx_nxt       = 1'b1;
            chk_nxt      = 1'b1;
            if (f.inq) begin
              rsel_nxt  = SEL_Q;
              ret_nxt   = ST_XQPUSH;
              state_nxt = ST_RM_A;
            end else begin
              hir_cnt_nxt = (hir_cnt_r == CNT_MAX) ? hir_cnt_r : hir_cnt_r + 1'b1;
              state_nxt   = ST_XQPUSH;
            end
          end
        end else if (f.hir) begin
          fl_req.wdata = '{hir: 1'b0, ins: 1'b1, inq: 1'b0};
          if (f.inq) begin
            hir_cnt_nxt = (hir_cnt_r == '0) ? hir_cnt_r : hir_cnt_r - 1'b1;
            rsel_nxt    = SEL_Q;
            ret_nxt     = ST_HB;
            state_nxt   = ST_RM_A;
          end else begin
            state_nxt = ST_HB;
          end
        end else begin
          fl_req.wdata = f;
          rsel_nxt     = SEL_S;
          ret_nxt      = ST_LC;
          state_nxt    = ST_RM_A;
        end
      end
      ST_XQPUSH: begin
        push_q    = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_HB: begin
        ry_nxt    = x_r;
        rsel_nxt  = SEL_S;
        ret_nxt   = ST_HC;
        state_nxt = ST_RM_A;
      end
      ST_HC: begin
        push_s    = 1'b1;
        state_nxt = ST_HD;
      end
      ST_HD: begin
        fl_req.re    = 1'b1;
        fl_req.raddr = s_bot_r;
        b_nxt        = s_bot_r;
        state_nxt    = ST_HE;
      end
      ST_HE: begin
        // demote the bottom of the stack into the queue
        fl_req.we    = 1'b1;
        fl_req.waddr = b_r;
        fl_req.wdata = '{hir: 1'b1, ins: f.ins, inq: 1'b1};
        if (b_r == x_r) begin
          hx_nxt = 1'b1;
        end
        if (f.inq) begin
          ry_nxt    = b_r;
          rsel_nxt  = SEL_Q;
          ret_nxt   = ST_HF;
          state_nxt = ST_RM_A;
        end else begin
          hir_cnt_nxt = (hir_cnt_r == CNT_MAX) ? hir_cnt_r : hir_cnt_r + 1'b1;
          state_nxt   = ST_HF;
        end
      end
      ST_HF: begin
        push_q    = 1'b1;
        push_y    = b_r;
        chk_nxt   = 1'b1;
        state_nxt = ST_PR;
      end
      ST_LC: begin
        push_s    = 1'b1;
        state_nxt = ST_PR;
      end
      ST_PR: begin
        if (s_ne_r) begin
          fl_req.re    = 1'b1;
          fl_req.raddr = s_bot_r;
          state_nxt    = ST_PR2;
        end else begin
          state_nxt = chk_r ? ST_CHECK : ST_FIN;
        end
      end
      ST_PR2: begin
        if (f.hir) begin
          fl_req.we    = 1'b1;
          fl_req.waddr = s_bot_r;
          fl_req.wdata = '{hir: f.hir, ins: 1'b0, inq: f.inq};
          ry_nxt       = s_bot_r;
          rsel_nxt     = SEL_S;
          ret_nxt      = ST_PR;
          state_nxt    = ST_RM_A;
        end else begin
          state_nxt = chk_r ? ST_CHECK : ST_FIN;
        end
      end
      ST_CHECK: begin
        if (hir_cnt_r > hir_lim_r && q_ne_r) begin
          fl_req.re    = 1'b1;
          fl_req.raddr = q_bot_r;
          vic_nxt      = q_bot_r;
          state_nxt    = ST_EV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_EV: begin
        fl_req.we    = 1'b1;
        fl_req.waddr = vic_r;
        fl_req.wdata = '{hir: f.hir, ins: f.ins, inq: 1'b0};
        hir_cnt_nxt  = (hir_cnt_r == '0) ? hir_cnt_r : hir_cnt_r - 1'b1;
        ev_nxt       = 1'b1;
        ry_nxt       = vic_r;
        rsel_nxt     = SEL_Q;
        ret_nxt      = ST_FIN;
        state_nxt    = ST_RM_A;
      end
      ST_RM_A: begin
        if (rsel_r) begin
          qp_req.re    = 1'b1;
          qp_req.raddr = ry_r;
          qn_req.re    = 1'b1;
          qn_req.raddr = ry_r;
        end else begin
          sp_req.re    = 1'b1;
          sp_req.raddr = ry_r;
          sn_req.re    = 1'b1;
          sn_req.raddr = ry_r;
        end
        state_nxt = ST_RM_B;
      end
      ST_RM_B: begin
        // unlink ry; end pointers move without touching the neighbor links
        if (ry_r == rm_bot && ry_r == rm_top) begin
          rm_ne = 1'b0;
        end else if (ry_r == rm_bot) begin
          rm_bot = rm_n;
        end else if (ry_r == rm_top) begin
          rm_top = rm_p;
        end else if (rsel_r) begin
          qn_req.we    = 1'b1;
          qn_req.waddr = rm_p;
          qn_req.wdata = rm_n;
          qp_req.we    = 1'b1;
          qp_req.waddr = rm_n;
          qp_req.wdata = rm_p;
        end else begin
          sn_req.we    = 1'b1;
          sn_req.waddr = rm_p;
          sn_req.wdata = rm_n;
          sp_req.we    = 1'b1;
          sp_req.waddr = rm_n;
          sp_req.wdata = rm_p;
        end
        if (rsel_r) begin
          q_bot_nxt = rm_bot;
          q_top_nxt = rm_top;
          q_ne_nxt  = rm_ne;
        end else begin
          s_bot_nxt = rm_bot;
          s_top_nxt = rm_top;
          s_ne_nxt  = rm_ne;
        end
        state_nxt = ret_r;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = ev_r;
          out_vic_nxt   = ID_W'(vic_r);
          out_hx_nxt    = hx_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (push_s) begin
      if (!s_ne_r) begin
        s_bot_nxt = push_y;
        s_top_nxt = push_y;
        s_ne_nxt  = 1'b1;
      end else begin
        sn_req.we    = 1'b1;
        sn_req.waddr = s_top_r;
        sn_req.wdata = push_y;
        sp_req.we    = 1'b1;
        sp_req.waddr = push_y;
        sp_req.wdata = s_top_r;
        s_top_nxt    = push_y;
      end
    end
    if (push_q) begin
      if (!q_ne_r) begin
        q_bot_nxt = push_y;
        q_top_nxt = push_y;
        q_ne_nxt  = 1'b1;
      end else begin
        qn_req.we    = 1'b1;
        qn_req.waddr = q_top_r;
        qn_req.wdata = push_y;
        qp_req.we    = 1'b1;
        qp_req.waddr = push_y;
        qp_req.wdata = q_top_r;
        q_top_nxt    = push_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      s_ne_r      <= 1'b0;
      q_ne_r      <= 1'b0;
      lir_cnt_r   <= '0;
      hir_cnt_r   <= '0;
      lir_lim_r   <= LIR_LIMIT_RST;
      hir_lim_r   <= HIR_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      s_ne_r      <= s_ne_nxt;
      q_ne_r      <= q_ne_nxt;
      lir_cnt_r   <= lir_cnt_nxt;
      hir_cnt_r   <= hir_cnt_nxt;
      lir_lim_r   <= lir_lim_nxt;
      hir_lim_r   <= hir_lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ret_r     <= ret_nxt;
    x_r       <= x_nxt;
    b_r       <= b_nxt;
    ry_r      <= ry_nxt;
    vic_r     <= vic_nxt;
    rsel_r    <= rsel_nxt;
    chk_r     <= chk_nxt;
    hx_r      <= hx_nxt;
    ev_r      <= ev_nxt;
    s_bot_r   <= s_bot_nxt;
    s_top_r   <= s_top_nxt;
    q_bot_r   <= q_bot_nxt;
    q_top_r   <= q_top_nxt;
    out_ev_r  <= out_ev_nxt;
    out_vic_r <= out_vic_nxt;
    out_hx_r  <= out_hx_nxt;
  end

endmodule

`default_nettype wire

// ----- design/lirs_replacement_engine_core.sv -----
// ----------------------------------------------------------------------------
// lirs_replacement_engine_core
// LIRS replacement bookkeeping: recency stack and resident HIR queue.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one access item (line_id) per valid/ready handshake.
//   out_ch returns exactly one result item per access: evicted, victim_id
//          (zero unless evicted) and the HIR mark of the accessed line.
//   cfg_ch writes lir_limit (index 0) or hir_limit (index 1); always ready,
//          to be written only while no access is in flight.
// Throughput:
//   one access at a time; each access steps through the sequencer states,
//   and each HIR entry pruned off the stack bottom adds a flag read, a flag
//   write and an unlink. The flag memory's single read port and the
//   registered read data of the link memories set this sequence.
// Reset:
//   rst_n (synchronous) empties both lists, zeros the counts and loads
//   the default limits; a clearing pass then walks the flag memory, one
//   entry a cycle over all 1024 entries, while in_ch stays not ready.
// Stall:
//   a finished result waits in the output register; the next access is
//   taken meanwhile and its result holds until the previous one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_replacement_engine_core import lirs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lirs_in_if.sink    in_ch,
  lirs_out_if.source out_ch,
  lirs_cfg_if.sink   cfg_ch
);

  flag_req_t          fl_req;
  link_req_t          sp_req, sn_req, qp_req, qn_req;
  logic [FLAGS_W-1:0] fl_rdata;
  logic [IDX_W-1:0]   sp_rdata, sn_rdata, qp_rdata, qn_rdata;

  lirs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_ch   (cfg_ch),
    .fl_req   (fl_req),
    .fl_rdata (fl_rdata),
    .sp_req   (sp_req),
    .sn_req   (sn_req),
    .qp_req   (qp_req),
    .qn_req   (qn_req),
    .sp_rdata (sp_rdata),
    .sn_rdata (sn_rdata),
    .qp_rdata (qp_rdata),
    .qn_rdata (qn_rdata)
  );

  lirs_ram #(.W(FLAGS_W), .D(LINES)) u_flags (
    .clk (clk), .we (fl_req.we), .waddr (fl_req.waddr), .wdata (fl_req.wdata),
    .re (fl_req.re), .raddr (fl_req.raddr), .rdata (fl_rdata)
  );

  // recency stack links
  lirs_ram #(.W(IDX_W), .D(LINES)) u_s_prev (
    .clk (clk), .we (sp_req.we), .waddr (sp_req.waddr), .wdata (sp_req.wdata),
    .re (sp_req.re), .raddr (sp_req.raddr), .rdata (sp_rdata)
  );

  lirs_ram #(.W(IDX_W), .D(LINES)) u_s_next (
    .clk (clk), .we (sn_req.we), .waddr (sn_req.waddr), .wdata (sn_req.wdata),
    .re (sn_req.re), .raddr (sn_req.raddr), .rdata (sn_rdata)
  );

  // resident HIR queue links
  lirs_ram #(.W(IDX_W), .D(LINES)) u_q_prev (
    .clk (clk), .we (qp_req.we), .waddr (qp_req.waddr), .wdata (qp_req.wdata),
    .re (qp_req.re), .raddr (qp_req.raddr), .rdata (qp_rdata)
  );

  lirs_ram #(.W(IDX_W), .D(LINES)) u_q_next (
    .clk (clk), .we (qn_req.we), .waddr (qn_req.waddr), .wdata (qn_req.wdata),
    .re (qn_req.re), .raddr (qn_req.raddr), .rdata (qn_rdata)
  );

endmodule

`default_nettype wire
